// ===== sv/a2r_pkg.sv =====
// ----------------------------------------------------------------------------
// a2r_pkg: shared definitions for the integer to Roman numeral converter
// Letter codes, the greedy letter table and the control/status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package a2r_pkg;

  // Field widths.
  localparam int ValueW  = 13;
  localparam int SymbolW = 7;

  // Largest value that has a numeral in this block.
  localparam logic [ValueW-1:0] ValueMax = 13'd4999;

  // ASCII codes of the Roman letters.
  localparam logic [SymbolW-1:0] SymI = 7'd73;
  localparam logic [SymbolW-1:0] SymV = 7'd86;
  localparam logic [SymbolW-1:0] SymX = 7'd88;
  localparam logic [SymbolW-1:0] SymL = 7'd76;
  localparam logic [SymbolW-1:0] SymC = 7'd67;
  localparam logic [SymbolW-1:0] SymD = 7'd68;
  localparam logic [SymbolW-1:0] SymM = 7'd77;

  // Greedy table, largest weight first. Subtractive pairs are two-letter
  // entries; the second letter goes out on the step after the first.
  localparam int NumEntries = 13;
  localparam int IdxW       = $clog2(NumEntries);

  localparam logic [ValueW-1:0] RomValue [NumEntries] = '{
    13'd1000, 13'd900, 13'd500, 13'd400, 13'd100, 13'd90, 13'd50,
    13'd40,   13'd10,  13'd9,   13'd5,   13'd4,   13'd1
  };

  localparam logic [SymbolW-1:0] RomFirst [NumEntries] = '{
    SymM, SymC, SymD, SymC, SymC, SymX, SymL,
    SymX, SymX, SymI, SymV, SymI, SymI
  };

  localparam logic [SymbolW-1:0] RomSecond [NumEntries] = '{
    SymM, SymM, SymD, SymD, SymC, SymC, SymL,
    SymL, SymX, SymX, SymV, SymV, SymI
  };

  localparam logic RomTwo [NumEntries] = '{
    1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0,
    1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0
  };

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture a new request value
    logic step;  // produce one letter into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic range_ok;   // request value lies in 1..4999
    logic step_last;  // the letter of this step ends the numeral
  } status_t;

endpackage

// ===== sv/a2r_value_if.sv =====
// ----------------------------------------------------------------------------
// a2r_value_if: request channel carrying the integer to convert
// Valid/ready handshake with a 13-bit unsigned value.
// ----------------------------------------------------------------------------
interface a2r_value_if;
  logic                           valid;
  logic                           ready;
  logic [a2r_pkg::ValueW-1:0]     value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ===== sv/a2r_symbol_if.sv =====
// ----------------------------------------------------------------------------
// a2r_symbol_if: result channel carrying one numeral letter
// Valid/ready handshake with an ASCII letter and an end-of-numeral flag.
// ----------------------------------------------------------------------------
interface a2r_symbol_if;
  logic                           valid;
  logic                           ready;
  logic [a2r_pkg::SymbolW-1:0]    symbol;
  logic                           last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

// ===== sv/a2r_ctrl.sv =====
// ----------------------------------------------------------------------------
// a2r_ctrl: sequencing controller for the Roman numeral converter
// Takes a request while idle, then steps the datapath once per free output
// slot until the final letter has been produced.
// ----------------------------------------------------------------------------
module a2r_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output a2r_pkg::cmd_t     cmd,
  input  a2r_pkg::status_t  status
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t state, state_next;
  logic   slot_free;

  // The output register can take a letter when empty or being drained.
  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE);

  // Commands to the datapath.
  always_comb begin
    cmd.load = in_valid && in_ready;
    cmd.step = (state == ST_RUN) && slot_free;
  end

  // Next state: out-of-range requests are accepted and dropped.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.load && status.range_ok) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (cmd.step && status.step_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/a2r_dpath.sv =====
// ----------------------------------------------------------------------------
// a2r_dpath: letter generator datapath
// Holds the remaining value, picks the largest table weight that fits,
// subtracts it and writes one letter per step into the output register.
// ----------------------------------------------------------------------------
module a2r_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  a2r_pkg::cmd_t                 cmd,
  output a2r_pkg::status_t              status,
  input  logic [a2r_pkg::ValueW-1:0]    value,
  output logic [a2r_pkg::SymbolW-1:0]   symbol,
  output logic                          last
);

  logic [a2r_pkg::ValueW-1:0]   rem;
  logic [a2r_pkg::ValueW-1:0]   rem_sub;
  logic                         pend;
  logic [a2r_pkg::SymbolW-1:0]  pend_sym;
  logic [a2r_pkg::IdxW-1:0]     sel;
  logic [a2r_pkg::SymbolW-1:0]  sym;
  logic                         fin;

  // Request range check.
  assign status.range_ok = (value != '0) && (value <= a2r_pkg::ValueMax);

  // Pick the largest weight not above the remainder, then form the letter.
  // A pending second letter of a subtractive pair takes precedence.
  always_comb begin
    sel = '0;
    for (int i = a2r_pkg::NumEntries - 1; i >= 0; i--) begin
      if (rem >= a2r_pkg::RomValue[i]) sel = a2r_pkg::IdxW'(i);
    end
    rem_sub = rem - a2r_pkg::RomValue[sel];
    if (pend) begin
      sym = pend_sym;
      fin = (rem == '0);
    end else begin
      sym = a2r_pkg::RomFirst[sel];
      fin = !a2r_pkg::RomTwo[sel] && (rem_sub == '0);
    end
  end

  assign status.step_last = fin;

  // Pending-letter flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (cmd.load) begin
      pend <= 1'b0;
    end else if (cmd.step) begin
      pend <= !pend && a2r_pkg::RomTwo[sel];
    end
  end

  // Remainder, second letter and output payload.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem <= value;
    end else if (cmd.step && !pend) begin
      rem <= rem_sub;
    end
    if (cmd.step && !pend) begin
      pend_sym <= a2r_pkg::RomSecond[sel];
    end
    if (cmd.step) begin
      symbol <= sym;
      last   <= fin;
    end
  end

endmodule

// ===== sv/arabic_to_roman_unit.sv =====
// ----------------------------------------------------------------------------
// arabic_to_roman_unit: integer to Roman numeral converter, top level
// Converts integers 1..4999 and streams their Roman numerals as ASCII letters.
// ----------------------------------------------------------------------------
// Each request on the number channel carries one integer; the unit answers
// with the letters of its Roman numeral on the numeral channel, most
// significant first, with last set on the final letter. Values of zero or
// above 4999 are accepted and produce no letters. A numeral has 1 to 16
// letters, produced one letter per cycle from the single greedy letter
// generator while the numeral channel does not stall, and a new request
// is taken in the idle cycle after the final letter is produced. The
// output register lets the final letter wait for its consumer while the
// next request is taken.
module arabic_to_roman_unit (
  input  logic                clk,
  input  logic                rst,
  a2r_value_if.sink           number,
  a2r_symbol_if.source        numeral
);

  a2r_pkg::cmd_t    cmd;
  a2r_pkg::status_t status;

  // Sequencing controller.
  a2r_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (number.valid),
    .in_ready  (number.ready),
    .out_valid (numeral.valid),
    .out_ready (numeral.ready),
    .cmd       (cmd),
    .status    (status)
  );

  // Letter generator datapath.
  a2r_dpath u_dpath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .status (status),
    .value  (number.value),
    .symbol (numeral.symbol),
    .last   (numeral.last)
  );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the integer to Roman numeral converter
// Sends numbers on the request channel, spells each accepted request into
// its expected letters, and checks every letter and end flag on the numeral
// channel. A directed table covers the single letters, the subtractive pairs,
// the longest numeral and the out-of-range values. Random requests follow,
// run under several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;

  localparam int                ValueW   = a2r_pkg::ValueW;
  localparam int                SymbolW  = a2r_pkg::SymbolW;
  localparam logic [ValueW-1:0] ValueMax = a2r_pkg::ValueMax;

  localparam int CycleLimit  = 400000;
  localparam int RandPerMode = 72;
  localparam int MaxReported = 10;

  // One expected letter of a numeral.
  typedef struct {
    logic [SymbolW-1:0] symbol;
    logic               last;
  } letter_t;

  // Per-request note: either a typed-in spelling or a call to the predictor.
  typedef struct {
    bit    typed;
    string spelled;
  } spelling_t;

  // Directed stimulus row.
  typedef struct {
    logic [ValueW-1:0] value;
    bit                typed;
    string             spelled;
  } dir_row_t;

  localparam int NumRows = 24;

  dir_row_t dir_rows [NumRows] = '{
    '{13'd1,    1'b1, "I"},
    '{13'd3,    1'b1, "III"},
    '{13'd4,    1'b1, "IV"},
    '{13'd5,    1'b1, "V"},
    '{13'd9,    1'b1, "IX"},
    '{13'd10,   1'b1, "X"},
    '{13'd40,   1'b1, "XL"},
    '{13'd50,   1'b1, "L"},
    '{13'd90,   1'b1, "XC"},
    '{13'd100,  1'b1, "C"},
    '{13'd400,  1'b1, "CD"},
    '{13'd500,  1'b1, "D"},
    '{13'd900,  1'b1, "CM"},
    '{13'd1000, 1'b1, "M"},
    '{13'd4000, 1'b1, "MMMM"},
    '{13'd4888, 1'b1, "MMMMDCCCLXXXVIII"},
    '{13'd4999, 1'b1, "MMMMCMXCIX"},
    '{13'd0,    1'b1, ""},
    '{13'd5000, 1'b1, ""},
    '{13'd8191, 1'b1, ""},
    '{13'd7,    1'b0, ""},
    '{13'd1994, 1'b0, ""},
    '{13'd2748, 1'b0, ""},
    '{13'd4096, 1'b0, ""}
  };

  logic clk;
  logic rst;

  a2r_value_if  number_if ();
  a2r_symbol_if numeral_if ();

  arabic_to_roman_unit u_top (
    .clk     (clk),
    .rst     (rst),
    .number  (number_if),
    .numeral (numeral_if)
  );

  letter_t   letter_q   [$];
  spelling_t spelling_q [$];

  int send_gap_pct;
  int stall_pct;
  int mismatches;
  int numbers_taken;
  int numbers_rejected;
  int letters_seen;
  int cycles;

  // Clock.
  initial begin
    clk = 1'b0;
  end

  always #4 clk = ~clk;

  // Letters of one decimal digit, given its unit, five and ten letters.
  function automatic string digit_letters(input int d, input string one,
                                          input string five, input string ten);
    string s;
    s = "";
    if (d == 9) begin
      s = {one, ten};
    end else if (d == 4) begin
      s = {one, five};
    end else begin
      if (d >= 5) begin
        s = five;
      end
      repeat (d % 5) s = {s, one};
    end
    return s;
  endfunction

  // Full Roman spelling of a number; empty when the number has none here.
  function automatic string roman_of(input logic [ValueW-1:0] v);
    string s;
    int    n;
    s = "";
    n = int'(v);
    if (v == '0 || v > ValueMax) begin
      return s;
    end
    repeat (n / 1000) s = {s, "M"};
    s = {s, digit_letters((n / 100) % 10, "C", "D", "M")};
    s = {s, digit_letters((n / 10) % 10, "X", "L", "C")};
    s = {s, digit_letters(n % 10, "I", "V", "X")};
    return s;
  endfunction

  // Random number: mostly valid, some short and some long numerals, a few
  // zero and above-range values.
  function automatic logic [ValueW-1:0] pick_number();
    int r;
    r = $urandom_range(99);
    if (r < 6) begin
      return '0;
    end else if (r < 14) begin
      return ValueW'($urandom_range(8191, 5000));
    end else if (r < 30) begin
      return ValueW'($urandom_range(60, 1));
    end else if (r < 45) begin
      return ValueW'(1000 * $urandom_range(4, 3) + 100 * $urandom_range(8, 7) +
                     10 * $urandom_range(8, 7) + $urandom_range(8, 7));
    end
    return ValueW'($urandom_range(4999, 1));
  endfunction

  // Log one bad letter; only the first few are printed.
  task automatic note_mismatch(input string what, input letter_t want,
                               input logic [SymbolW-1:0] got_sym, input logic got_last);
    mismatches++;
    if (mismatches <= MaxReported) begin
      $display("%0t: %s: expected '%c' last=%0b, got '%c' (%0d) last=%0b",
               $realtime, what, want.symbol, want.last, got_sym, got_sym, got_last);
    end
  endtask

  // Offer one request, with random gaps ahead of it. Valid stays high after
  // acceptance so that back-to-back requests never toggle it within a step.
  task automatic send_number(input logic [ValueW-1:0] v, input bit typed,
                             input string spelled);
    spelling_t tag;
    while ($urandom_range(99) < send_gap_pct) begin
      number_if.valid <= 1'b0;
      number_if.value <= ValueW'($urandom);
      @(posedge clk);
    end
    tag.typed   = typed;
    tag.spelled = spelled;
    spelling_q.push_back(tag);
    number_if.valid <= 1'b1;
    number_if.value <= v;
    @(posedge clk);
    while (!number_if.ready) @(posedge clk);
  endtask

  // Receiver back-pressure.
  always @(posedge clk) begin
    numeral_if.ready <= rst ? 1'b0 : ($urandom_range(99) >= stall_pct);
  end

  // Spell accepted requests into expected letters, then check each letter.
  always @(posedge clk) begin : watch
    spelling_t tag;
    string     spelled;
    letter_t   want;
    byte       ch;
    if (!rst) begin
      if (number_if.valid && number_if.ready) begin
        tag = spelling_q.pop_front();
        spelled = tag.typed ? tag.spelled : roman_of(number_if.value);
        numbers_taken++;
        if (spelled.len() == 0) begin
          numbers_rejected++;
        end
        for (int i = 0; i < spelled.len(); i++) begin
          ch = spelled[i];
          want.symbol = ch[SymbolW-1:0];
          want.last   = (i == spelled.len() - 1);
          letter_q.push_back(want);
        end
      end
      if (numeral_if.valid && numeral_if.ready) begin
        letters_seen++;
        if (letter_q.size() == 0) begin
          want.symbol = '0;
          want.last   = 1'b0;
          note_mismatch("letter with nothing pending", want, numeral_if.symbol,
                        numeral_if.last);
        end else begin
          want = letter_q.pop_front();
          if (numeral_if.symbol !== want.symbol || numeral_if.last !== want.last) begin
            note_mismatch("wrong letter", want, numeral_if.symbol, numeral_if.last);
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Timed out after %0d cycles with %0d letters still pending",
               cycles, letter_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Main sequence.
  initial begin
    rst              = 1'b1;
    number_if.valid  = 1'b0;
    number_if.value  = '0;
    numeral_if.ready = 1'b0;
    send_gap_pct     = 0;
    stall_pct        = 0;
    mismatches       = 0;
    numbers_taken    = 0;
    numbers_rejected = 0;
    letters_seen     = 0;
    cycles           = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table with no idling on either side.
    for (int i = 0; i < NumRows; i++) begin
      send_number(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].spelled);
    end

    // Random requests under each idling pattern.
    for (int mode = 0; mode < 4; mode++) begin
      unique case (mode)
        0: begin
          send_gap_pct = 0;
          stall_pct    = 0;
        end
        1: begin
          send_gap_pct = 58;
          stall_pct    = 0;
        end
        2: begin
          send_gap_pct = 0;
          stall_pct    = 58;
        end
        default: begin
          send_gap_pct = 25;
          stall_pct    = 25;
        end
      endcase
      for (int k = 0; k < RandPerMode; k++) begin
        send_number(pick_number(), 1'b0, "");
      end
    end
    number_if.valid <= 1'b0;

    // Drain, then allow the block to settle.
    while (letter_q.size() != 0 || spelling_q.size() != 0) @(posedge clk);
    repeat (32) @(posedge clk);

    $display("Converted %0d numbers (%0d with no numeral) into %0d letters",
             numbers_taken, numbers_rejected, letters_seen);
    $display("under four sender/receiver idling patterns; %0d bad letters",
             mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== arabic_to_roman_unit.f =====
sv/a2r_pkg.sv
sv/a2r_value_if.sv
sv/a2r_symbol_if.sv
sv/a2r_ctrl.sv
sv/a2r_dpath.sv
sv/arabic_to_roman_unit.sv
dv/tb.sv
